// ===== design/icbt_pkg.sv =====
// Shared constants, types and result codes of the interval booking table.
// Used by icbt_cell and interval_conflict_booking_table_core.
package icbt_pkg;

  localparam int ENTRIES    = 64;
  localparam int TIME_WIDTH = 32;
  localparam int PORT_TW    = 32;
  localparam int CNT_OUT_W  = 7;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic  valid;
    time_t lo;
    time_t hi;
    cnt_t  rem;
    logic  clash;
    logic  booked;
  } tok_t;

endpackage

// ===== design/icbt_cell.sv =====
// One cell of the booking chain: holds one stored interval and passes the
// request word to its neighbor each cycle. Depends on icbt_pkg.
module icbt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  icbt_pkg::tok_t tok_i,
  output icbt_pkg::tok_t tok_o
);
  import icbt_pkg::*;

  time_t start_r;
  time_t end_r;
  tok_t  tok_r;
  tok_t  tok_nxt;
  logic  hit;
  logic  wr;

  assign hit = (tok_i.lo < end_r) && (tok_i.hi > start_r);
  assign wr  = tok_i.valid && (tok_i.rem == '0) && !tok_i.clash && !tok_i.booked;

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.rem != '0) begin
      tok_nxt.clash = tok_i.clash | hit;
      tok_nxt.rem   = tok_i.rem - cnt_t'(1);
    end else if (wr) begin
      tok_nxt.booked = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.lo     <= tok_nxt.lo;
    tok_r.hi     <= tok_nxt.hi;
    tok_r.rem    <= tok_nxt.rem;
    tok_r.clash  <= tok_nxt.clash;
    tok_r.booked <= tok_nxt.booked;
    if (wr) begin
      start_r <= tok_i.lo;
      end_r   <= tok_i.hi;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== design/interval_conflict_booking_table_core.sv =====
// Interval booking table top level: chain of ENTRIES cells, entry count and
// result register. Depends on icbt_pkg and icbt_cell.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_start_time, in_end_time
//   out_     output     out_valid / out_stall out_accepted, out_status,
//                                            out_stored_count
//
// A request word walks the cell chain, one cell per cycle, and out_valid is
// registered once the word leaves the last cell of the chain.
// One request is in flight at a time; the next is accepted in the cycle its
// predecessor's result is taken.
// Reset clears the entry count and all flow control; stored intervals are not cleared.
// in_stall stays high while a request is in flight or its result waits.
module interval_conflict_booking_table_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [icbt_pkg::PORT_TW-1:0]   in_start_time,
  input  logic [icbt_pkg::PORT_TW-1:0]   in_end_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic [1:0]                     out_status,
  output logic [icbt_pkg::CNT_OUT_W-1:0] out_stored_count
);
  import icbt_pkg::*;

  tok_t    tok [ENTRIES+1];
  logic    busy_r, busy_nxt;
  cnt_t    count_r, count_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    accepted_r;
  status_t status_r, status_nxt;
  logic    in_acc, out_done;
  tok_t    tok_last;

  assign out_done = out_valid_r && !out_stall;
  assign in_stall = busy_r && !out_done;
  assign in_acc   = in_valid && !in_stall;

  assign tok[0] = {in_acc, time_t'(in_start_time), time_t'(in_end_time), count_r,
                   1'b0, 1'b0};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    icbt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  assign tok_last = tok[ENTRIES];

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    if (out_done) begin
      out_valid_nxt = 1'b0;
      busy_nxt      = 1'b0;
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
    end
    if (tok_last.valid) begin
      out_valid_nxt = 1'b1;
      if (tok_last.booked) begin
        status_nxt = ST_BOOKED;
        count_nxt  = count_r + cnt_t'(1);
      end else if (tok_last.clash) begin
        status_nxt = ST_OVERLAP;
      end else begin
        status_nxt = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (tok_last.valid) begin
      accepted_r <= tok_last.booked;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = accepted_r;
  assign out_status       = status_r;
  assign out_stored_count = CNT_OUT_W'(count_r);

endmodule
